FILE: src/calac_pkg.sv
package calac_pkg;

	localparam int OP_W      = 2;
	localparam int UID_W     = 56;
	localparam int LEN_W     = 3;
	localparam int IDX_W     = 4;
	localparam int DUTY_W    = 8;
	localparam int EV_W      = 3;
	localparam int LED_W     = 2;
	localparam int HOLD_W    = 16;
	localparam int COOL_W    = 16;
	localparam int PULSE_W   = 10;
	localparam int SINCE_W   = 16;
	localparam int ELAPSED_W = HOLD_W + 1;
	localparam int UID_BYTES = UID_W / 8;

	localparam int TABLE_ENTRIES_DEF = 16;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_CARD  = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

	localparam logic [EV_W-1:0] EV_NONE        = 3'd0;
	localparam logic [EV_W-1:0] EV_IGNORED     = 3'd1;
	localparam logic [EV_W-1:0] EV_GRANTED     = 3'd2;
	localparam logic [EV_W-1:0] EV_DENIED      = 3'd3;
	localparam logic [EV_W-1:0] EV_WRITTEN     = 3'd4;
	localparam logic [EV_W-1:0] EV_REL_OPEN    = 3'd5;
	localparam logic [EV_W-1:0] EV_REL_TIMEOUT = 3'd6;

	localparam logic [LED_W-1:0] LED_GREEN = 2'd0;
	localparam logic [LED_W-1:0] LED_BLUE  = 2'd1;
	localparam logic [LED_W-1:0] LED_RED   = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_HOLD     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COOLDOWN = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PULSE    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STRONG   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WEAK     = 3'd4;

	localparam logic [HOLD_W-1:0]  HOLD_RST     = 16'd5000;
	localparam logic [COOL_W-1:0]  COOLDOWN_RST = 16'd2000;
	localparam logic [PULSE_W-1:0] PULSE_RST    = 10'd300;
	localparam logic [DUTY_W-1:0]  STRONG_RST   = 8'd255;
	localparam logic [DUTY_W-1:0]  WEAK_RST     = 8'd25;

	localparam logic [SINCE_W-1:0]   SINCE_MAX   = '1;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	typedef struct packed {
		logic [HOLD_W-1:0]  hold_ms;
		logic [COOL_W-1:0]  cooldown_ms;
		logic [PULSE_W-1:0] pulse_ms;
		logic [DUTY_W-1:0]  strong_duty;
		logic [DUTY_W-1:0]  weak_duty;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [UID_W-1:0] card_uid;
		logic [LEN_W-1:0] card_uid_len;
		logic [IDX_W-1:0] entry_index;
		logic             entry_valid;
		logic             switch_closed;
	} item_t;

	typedef struct packed {
		logic [DUTY_W-1:0] solenoid_duty;
		logic [EV_W-1:0]   event_res;
		logic [LED_W-1:0]  led_color;
		logic              log_valid;
		logic [UID_W-1:0]  log_uid;
		logic [LEN_W-1:0]  log_uid_len;
	} result_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [UID_W-1:0] uid;
		logic [LEN_W-1:0] len;
		logic             valid;
	} tbl_wr_t;

	// Keeps the low len bytes of a UID; a length of seven or more keeps all.
	function automatic logic [UID_W-1:0] uid_bits(input logic [UID_W-1:0] uid,
		input logic [LEN_W-1:0] len);
		logic [UID_W-1:0] r;
		r = '0;
		for (int b = 0; b < UID_BYTES; b++) begin
			if (b < int'(len))
				r[b*8 +: 8] = uid[b*8 +: 8];
		end
		return r;
	endfunction

endpackage

FILE: src/calac_if.sv
interface calac_item_if;
	logic                           valid;
	logic                           ready;
	logic [calac_pkg::OP_W-1:0]     opcode;
	logic [calac_pkg::UID_W-1:0]    card_uid;
	logic [calac_pkg::LEN_W-1:0]    card_uid_len;
	logic [calac_pkg::IDX_W-1:0]    entry_index;
	logic                           entry_valid;
	logic                           switch_closed;

	modport source (output valid, opcode, card_uid, card_uid_len, entry_index,
		entry_valid, switch_closed, input ready);
	modport sink (input valid, opcode, card_uid, card_uid_len, entry_index,
		entry_valid, switch_closed, output ready);
endinterface

interface calac_result_if;
	logic                           valid;
	logic                           ready;
	logic [calac_pkg::DUTY_W-1:0]   solenoid_duty;
	logic [calac_pkg::EV_W-1:0]     event_res;
	logic [calac_pkg::LED_W-1:0]    led_color;
	logic                           log_valid;
	logic [calac_pkg::UID_W-1:0]    log_uid;
	logic [calac_pkg::LEN_W-1:0]    log_uid_len;

	modport source (output valid, solenoid_duty, event_res, led_color, log_valid,
		log_uid, log_uid_len, input ready);
	modport sink (input valid, solenoid_duty, event_res, led_color, log_valid,
		log_uid, log_uid_len, output ready);
endinterface

FILE: src/card_access_lock_controller.sv
// A request is registered at acceptance, and its result is registered when the
// stage advances. Throughput: one request per cycle unless the output stalls;
// all table slots are compared in parallel.
// Reset (arst_n, asynchronous): table valid bits, lock state and pipeline
// valids clear, the configuration registers return to their defaults.
module card_access_lock_controller #(
	parameter int TABLE_ENTRIES = calac_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	calac_item_if.sink                       in_item,
	calac_result_if.source                   out_res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [calac_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [calac_pkg::APB_DATA_W-1:0] pwdata,
	output logic [calac_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready
);
	import calac_pkg::*;

	cfg_t             cfg;
	item_t            item_s1;
	logic             valid_s1;
	result_t          res_next;
	result_t          res_s2;
	logic             valid_s2;
	logic             advance;
	logic             in_fire;
	logic             hit;
	logic             wr_in_range;
	tbl_wr_t          wr;
	logic [UID_W-1:0] lk_uid;
	logic [LEN_W-1:0] lk_len;

	assign advance       = valid_s1 && (!valid_s2 || out_res.ready);
	assign in_item.ready = !valid_s1 || advance;
	assign in_fire       = in_item.valid && in_item.ready;

	calac_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	calac_uid_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.wr_in_range (wr_in_range),
		.lk_uid      (lk_uid),
		.lk_len      (lk_len),
		.hit         (hit)
	);

	calac_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item        (item_s1),
		.advance     (advance),
		.hit         (hit),
		.wr_in_range (wr_in_range),
		.lk_uid      (lk_uid),
		.lk_len      (lk_len),
		.wr          (wr),
		.res         (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_item.ready)
				valid_s1 <= in_item.valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_res.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.opcode        <= in_item.opcode;
			item_s1.card_uid      <= in_item.card_uid;
			item_s1.card_uid_len  <= in_item.card_uid_len;
			item_s1.entry_index   <= in_item.entry_index;
			item_s1.entry_valid   <= in_item.entry_valid;
			item_s1.switch_closed <= in_item.switch_closed;
		end
		if (advance)
			res_s2 <= res_next;
	end

	assign out_res.valid         = valid_s2;
	assign out_res.solenoid_duty = res_s2.solenoid_duty;
	assign out_res.event_res     = res_s2.event_res;
	assign out_res.led_color     = res_s2.led_color;
	assign out_res.log_valid     = res_s2.log_valid;
	assign out_res.log_uid       = res_s2.log_uid;
	assign out_res.log_uid_len   = res_s2.log_uid_len;

`ifndef SYNTHESIS
	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("processed request did not reach the result register");

	a_log_only_on_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.log_valid) |-> res_s2.event_res == EV_GRANTED)
		else $error("log record requested without a grant");

	a_denied_cuts_power: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_res == EV_DENIED) |->
		(res_s2.solenoid_duty == '0 && res_s2.led_color == LED_RED))
		else $error("denied card left the solenoid powered or not red");

	a_stall_blocks_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_res.ready) |-> !in_item.ready)
		else $error("input taken while the pipeline is full and stalled");
`endif

endmodule

FILE: src/calac_cfg_regs.sv
module calac_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [calac_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [calac_pkg::APB_DATA_W-1:0] pwdata,
	output logic [calac_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready,
	output calac_pkg::cfg_t                  cfg
);
	import calac_pkg::*;

	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	cfg_t                 cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ms     <= HOLD_RST;
			cfg_q.cooldown_ms <= COOLDOWN_RST;
			cfg_q.pulse_ms    <= PULSE_RST;
			cfg_q.strong_duty <= STRONG_RST;
			cfg_q.weak_duty   <= WEAK_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HOLD:     cfg_q.hold_ms     <= pwdata[HOLD_W-1:0];
				REG_COOLDOWN: cfg_q.cooldown_ms <= pwdata[COOL_W-1:0];
				REG_PULSE:    cfg_q.pulse_ms    <= pwdata[PULSE_W-1:0];
				REG_STRONG:   cfg_q.strong_duty <= pwdata[DUTY_W-1:0];
				REG_WEAK:     cfg_q.weak_duty   <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HOLD:     prdata = APB_DATA_W'(cfg_q.hold_ms);
			REG_COOLDOWN: prdata = APB_DATA_W'(cfg_q.cooldown_ms);
			REG_PULSE:    prdata = APB_DATA_W'(cfg_q.pulse_ms);
			REG_STRONG:   prdata = APB_DATA_W'(cfg_q.strong_duty);
			REG_WEAK:     prdata = APB_DATA_W'(cfg_q.weak_duty);
			default:      prdata = '0;
		endcase
	end

endmodule

FILE: src/calac_uid_table.sv
module calac_uid_table #(
	parameter int TABLE_ENTRIES = calac_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  calac_pkg::tbl_wr_t          wr,
	output logic                        wr_in_range,
	input  logic [calac_pkg::UID_W-1:0] lk_uid,
	input  logic [calac_pkg::LEN_W-1:0] lk_len,
	output logic                        hit
);
	import calac_pkg::*;

	localparam int TIW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [UID_W-1:0]         uid_q [TABLE_ENTRIES];
	logic [LEN_W-1:0]         len_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TIW-1:0]           wsel;

	assign wr_in_range = int'(wr.idx) < TABLE_ENTRIES;
	assign wsel        = TIW'(wr.idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en && wr_in_range) begin
			valid_q[wsel] <= wr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr_in_range) begin
			uid_q[wsel] <= wr.uid;
			len_q[wsel] <= wr.len;
		end
	end

	// Every slot is compared at once; the core ignores the hit for a zero lookup length.
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (valid_q[i] && len_q[i] == lk_len && uid_q[i] == lk_uid)
				hit = 1'b1;
		end
	end

endmodule

FILE: src/calac_core.sv
module calac_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  calac_pkg::cfg_t             cfg,
	input  calac_pkg::item_t            item,
	input  logic                        advance,
	input  logic                        hit,
	input  logic                        wr_in_range,
	output logic [calac_pkg::UID_W-1:0] lk_uid,
	output logic [calac_pkg::LEN_W-1:0] lk_len,
	output calac_pkg::tbl_wr_t          wr,
	output calac_pkg::result_t          res
);
	import calac_pkg::*;

	logic [UID_W-1:0]     recent_uid_q,  recent_uid_d;
	logic [LEN_W-1:0]     recent_len_q,  recent_len_d;
	logic                 recent_valid_q, recent_valid_d;
	logic [SINCE_W-1:0]   since_q,       since_d;
	logic                 unlock_q,      unlock_d;
	logic [PULSE_W-1:0]   pulse_left_q,  pulse_left_d;
	logic [ELAPSED_W-1:0] elapsed_q,     elapsed_d;
	logic [DUTY_W-1:0]    duty_q,        duty_d;

	logic [UID_W-1:0]     uid_m;
	logic [EV_W-1:0]      ev;
	logic                 repeat_card;

	assign uid_m  = uid_bits(item.card_uid, item.card_uid_len);
	assign lk_uid = uid_m;
	assign lk_len = item.card_uid_len;

	assign wr.en    = advance && item.opcode == OP_WRITE;
	assign wr.idx   = item.entry_index;
	assign wr.uid   = uid_m;
	assign wr.len   = item.card_uid_len;
	assign wr.valid = item.entry_valid;

	assign repeat_card = recent_valid_q && recent_uid_q == uid_m &&
		recent_len_q == item.card_uid_len && since_q < cfg.cooldown_ms;

	always_comb begin
		recent_uid_d   = recent_uid_q;
		recent_len_d   = recent_len_q;
		recent_valid_d = recent_valid_q;
		since_d        = since_q;
		unlock_d       = unlock_q;
		pulse_left_d   = pulse_left_q;
		elapsed_d      = elapsed_q;
		duty_d         = duty_q;
		ev             = EV_NONE;

		unique case (item.opcode)
			OP_TICK: begin
				if (since_q != SINCE_MAX)
					since_d = since_q + 1'b1;
				if (unlock_q) begin
					if (pulse_left_q != '0) begin
						pulse_left_d = pulse_left_q - 1'b1;
						if (pulse_left_q == PULSE_W'(1))
							duty_d = cfg.weak_duty;
					end else begin
						if (elapsed_q != ELAPSED_MAX)
							elapsed_d = elapsed_q + 1'b1;
						// An open switch wins over the timeout.
						if (elapsed_d >= ELAPSED_W'(cfg.hold_ms)) begin
							if (!item.switch_closed)
								ev = EV_REL_OPEN;
							else if (elapsed_d >= {cfg.hold_ms, 1'b0})
								ev = EV_REL_TIMEOUT;
						end
						if (ev != EV_NONE) begin
							duty_d   = '0;
							unlock_d = 1'b0;
						end
					end
				end
			end
			OP_CARD: begin
				if (item.card_uid_len != '0) begin
					if (repeat_card) begin
						ev = EV_IGNORED;
					end else begin
						recent_uid_d   = uid_m;
						recent_len_d   = item.card_uid_len;
						recent_valid_d = 1'b1;
						since_d        = '0;
						if (hit) begin
							ev           = EV_GRANTED;
							unlock_d     = 1'b1;
							elapsed_d    = '0;
							pulse_left_d = cfg.pulse_ms;
							duty_d       = (cfg.pulse_ms != '0) ? cfg.strong_duty
								: cfg.weak_duty;
						end else begin
							ev           = EV_DENIED;
							duty_d       = '0;
							unlock_d     = 1'b0;
							pulse_left_d = '0;
						end
					end
				end
			end
			OP_WRITE: begin
				if (wr_in_range)
					ev = EV_WRITTEN;
			end
			OP_NOP: ;
			default: ;
		endcase

		res.solenoid_duty = duty_d;
		res.event_res     = ev;
		if (ev == EV_DENIED)
			res.led_color = LED_RED;
		else if (item.switch_closed)
			res.led_color = LED_GREEN;
		else
			res.led_color = LED_BLUE;
		res.log_valid   = ev == EV_GRANTED;
		res.log_uid     = (ev == EV_GRANTED) ? uid_m : '0;
		res.log_uid_len = (ev == EV_GRANTED) ? item.card_uid_len : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_uid_q   <= '0;
			recent_len_q   <= '0;
			recent_valid_q <= 1'b0;
			since_q        <= SINCE_MAX;
			unlock_q       <= 1'b0;
			pulse_left_q   <= '0;
			elapsed_q      <= '0;
			duty_q         <= '0;
		end else if (advance) begin
			recent_uid_q   <= recent_uid_d;
			recent_len_q   <= recent_len_d;
			recent_valid_q <= recent_valid_d;
			since_q        <= since_d;
			unlock_q       <= unlock_d;
			pulse_left_q   <= pulse_left_d;
			elapsed_q      <= elapsed_d;
			duty_q         <= duty_d;
		end
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import calac_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [UID_W-1:0] UID_ONES = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;

	calac_item_if item_ch ();
	calac_result_if res_ch ();

	card_access_lock_controller dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (item_ch.sink),
		.out_res (res_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	item_t door_requests[$];
	result_t expected_outcomes[$];
	item_t next_req;
	logic item_taken = 1'b0;
	logic res_taken = 1'b0;
	int send_wait = 0;
	int recv_wait = 0;
	bit send_fast = 1'b0;
	bit recv_fast = 1'b0;
	int mismatches = 0;
	int cycles = 0;

	// Predicted lock state and configuration.
	cfg_t cfg;
	logic [UID_W-1:0] acl_uid[TABLE_ENTRIES_DEF];
	logic [LEN_W-1:0] acl_len[TABLE_ENTRIES_DEF];
	logic acl_ok[TABLE_ENTRIES_DEF];
	logic [UID_W-1:0] prev_uid;
	logic [LEN_W-1:0] prev_len;
	logic prev_seen;
	logic [SINCE_W-1:0] since_card;
	logic unlocked;
	logic [PULSE_W-1:0] pulse_cnt;
	logic [ELAPSED_W-1:0] held;
	logic [DUTY_W-1:0] duty;

	// What the stimulus has put into the table, so that cards can hit it.
	logic [UID_W-1:0] gen_uid[TABLE_ENTRIES_DEF];
	logic [LEN_W-1:0] gen_len[TABLE_ENTRIES_DEF];
	bit gen_set[TABLE_ENTRIES_DEF];
	logic [UID_W-1:0] gen_prev_uid = '0;
	logic [LEN_W-1:0] gen_prev_len = '0;

	function automatic logic [UID_W-1:0] uid_mask(input logic [LEN_W-1:0] len);
		logic [UID_W-1:0] one;
		one = 1;
		return (len >= 7) ? '1 : ((one << (8 * len)) - one);
	endfunction

	function automatic result_t predict_outcome(input item_t it);
		result_t res;
		logic [UID_W-1:0] key;
		logic [EV_W-1:0] ev;
		logic hit;
		res = '0;
		ev = EV_NONE;
		hit = 1'b0;
		key = it.card_uid & uid_mask(it.card_uid_len);
		case (it.opcode)
			OP_TICK: begin
				if (since_card != SINCE_MAX)
					since_card++;
				if (unlocked) begin
					if (pulse_cnt != 0) begin
						pulse_cnt--;
						if (pulse_cnt == 0)
							duty = cfg.weak_duty;
					end else begin
						if (held != ELAPSED_MAX)
							held++;
						if (held >= cfg.hold_ms) begin
							if (!it.switch_closed)
								ev = EV_REL_OPEN;
							else if (held >= {cfg.hold_ms, 1'b0})
								ev = EV_REL_TIMEOUT;
							if (ev != EV_NONE) begin
								duty = '0;
								unlocked = 1'b0;
							end
						end
					end
				end
			end
			OP_CARD: begin
				if (it.card_uid_len != 0) begin
					if (prev_seen && prev_uid == key && prev_len == it.card_uid_len &&
						since_card < cfg.cooldown_ms) begin
						ev = EV_IGNORED;
					end else begin
						prev_uid = key;
						prev_len = it.card_uid_len;
						prev_seen = 1'b1;
						since_card = '0;
						for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
							if (acl_ok[i] && acl_len[i] == it.card_uid_len && acl_uid[i] == key)
								hit = 1'b1;
						if (hit) begin
							ev = EV_GRANTED;
							unlocked = 1'b1;
							held = '0;
							pulse_cnt = cfg.pulse_ms;
							duty = (cfg.pulse_ms != 0) ? cfg.strong_duty : cfg.weak_duty;
							res.log_valid = 1'b1;
							res.log_uid = key;
							res.log_uid_len = it.card_uid_len;
						end else begin
							ev = EV_DENIED;
							duty = '0;
							unlocked = 1'b0;
							pulse_cnt = '0;
						end
					end
				end
			end
			OP_WRITE: begin
				acl_uid[it.entry_index] = key;
				acl_len[it.entry_index] = it.card_uid_len;
				acl_ok[it.entry_index] = it.entry_valid;
				ev = EV_WRITTEN;
			end
			default: ;
		endcase
		res.solenoid_duty = duty;
		res.event_res = ev;
		res.led_color = (ev == EV_DENIED) ? LED_RED : (it.switch_closed ? LED_GREEN : LED_BLUE);
		return res;
	endfunction

	function automatic logic [UID_W-1:0] rand_uid();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[UID_W-1:0];
	endfunction

	// Every field random; callers then set the ones that matter.
	function automatic item_t noise_item(input logic [OP_W-1:0] op);
		item_t it;
		it.opcode = op;
		it.card_uid = rand_uid();
		it.card_uid_len = LEN_W'($urandom_range(0, 7));
		it.entry_index = IDX_W'($urandom_range(0, TABLE_ENTRIES_DEF - 1));
		it.entry_valid = 1'($urandom_range(0, 1));
		it.switch_closed = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic item_t tick_item(input logic closed);
		item_t it;
		it = noise_item(OP_TICK);
		it.switch_closed = closed;
		return it;
	endfunction

	// Bytes above the length are filled with junk, which the block must ignore.
	function automatic item_t card_item(input logic [UID_W-1:0] uid,
		input logic [LEN_W-1:0] len);
		item_t it;
		logic [UID_W-1:0] m;
		m = uid_mask(len);
		it = noise_item(OP_CARD);
		it.card_uid = (uid & m) | (rand_uid() & ~m);
		it.card_uid_len = len;
		gen_prev_uid = uid;
		gen_prev_len = len;
		return it;
	endfunction

	function automatic item_t write_item(input int slot, input logic [UID_W-1:0] uid,
		input logic [LEN_W-1:0] len, input logic ok);
		item_t it;
		it = noise_item(OP_WRITE);
		it.entry_index = IDX_W'(slot);
		it.card_uid = uid;
		it.card_uid_len = len;
		it.entry_valid = ok;
		gen_uid[slot] = uid;
		gen_len[slot] = len;
		gen_set[slot] = 1'b1;
		return it;
	endfunction

	// Mostly ticks and cards, many taken from the table, so grants and releases recur.
	function automatic item_t rand_item();
		int pick, slot;
		item_t it;
		pick = $urandom_range(0, 99);
		slot = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
		if (pick < 12) begin
			it = write_item(slot, rand_uid(), LEN_W'($urandom_range(0, 7)),
				$urandom_range(0, 4) != 0);
		end else if (pick < 40) begin
			pick = $urandom_range(0, 9);
			if (pick < 5 && gen_set[slot])
				it = card_item(gen_uid[slot], gen_len[slot]);
			else if (pick < 7)
				it = card_item(gen_prev_uid, gen_prev_len);
			else if (pick < 9)
				it = card_item(rand_uid(), LEN_W'($urandom_range(1, 7)));
			else
				it = card_item(rand_uid(), 0);
		end else if (pick < 95) begin
			it = tick_item($urandom_range(0, 3) != 0);
		end else begin
			it = noise_item(OP_NOP);
		end
		return it;
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_HOLD: cfg.hold_ms = value[HOLD_W-1:0];
			REG_COOLDOWN: cfg.cooldown_ms = value[COOL_W-1:0];
			REG_PULSE: cfg.pulse_ms = value[PULSE_W-1:0];
			REG_STRONG: cfg.strong_duty = value[DUTY_W-1:0];
			REG_WEAK: cfg.weak_duty = value[DUTY_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_cfg(input int hold, input int cool, input int pulse, input int hi_duty,
		input int lo_duty);
		write_reg(REG_HOLD, hold);
		write_reg(REG_COOLDOWN, cool);
		write_reg(REG_PULSE, pulse);
		write_reg(REG_STRONG, hi_duty);
		write_reg(REG_WEAK, lo_duty);
	endtask

	task automatic add_req(input item_t it);
		door_requests.insert(door_requests.size(), it);
	endtask

	// The check waits past the falling edge so that the driver's update is seen.
	task automatic drain();
		do begin
			@(negedge clk);
			#1;
		end while (door_requests.size() != 0 || item_ch.valid || expected_outcomes.size() != 0);
	endtask

	task automatic push_random(input int n);
		repeat (n) add_req(rand_item());
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Request driver.
	always @(negedge clk) begin
		if (arst_n && (!item_ch.valid || item_taken)) begin
			if (send_wait != 0) begin
				item_ch.valid <= 1'b0;
				send_wait--;
			end else if (door_requests.size() != 0) begin
				next_req = door_requests.pop_front();
				item_ch.opcode <= next_req.opcode;
				item_ch.card_uid <= next_req.card_uid;
				item_ch.card_uid_len <= next_req.card_uid_len;
				item_ch.entry_index <= next_req.entry_index;
				item_ch.entry_valid <= next_req.entry_valid;
				item_ch.switch_closed <= next_req.switch_closed;
				item_ch.valid <= 1'b1;
				if ($urandom_range(0, 15) == 0)
					send_fast = !send_fast;
				send_wait = send_fast ? 0 : $urandom_range(0, 3);
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: the stall count runs down only while a result is offered.
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken) begin
				if ($urandom_range(0, 15) == 0)
					recv_fast = !recv_fast;
				recv_wait = recv_fast ? 0 : $urandom_range(0, 3);
			end
			res_ch.ready <= (recv_wait == 0);
			if (res_ch.valid && recv_wait != 0)
				recv_wait--;
		end
	end

	// Monitor: results are checked before the new request is predicted.
	always @(posedge clk) begin
		item_taken <= item_ch.valid && item_ch.ready;
		res_taken <= res_ch.valid && res_ch.ready;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_outcomes.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					check_field("solenoid_duty", 64'(expected_outcomes[0].solenoid_duty),
						64'(res_ch.solenoid_duty));
					check_field("event_res", 64'(expected_outcomes[0].event_res),
						64'(res_ch.event_res));
					check_field("led_color", 64'(expected_outcomes[0].led_color),
						64'(res_ch.led_color));
					check_field("log_valid", 64'(expected_outcomes[0].log_valid),
						64'(res_ch.log_valid));
					check_field("log_uid", 64'(expected_outcomes[0].log_uid),
						64'(res_ch.log_uid));
					check_field("log_uid_len", 64'(expected_outcomes[0].log_uid_len),
						64'(res_ch.log_uid_len));
					void'(expected_outcomes.pop_front());
				end
			end
			if (item_ch.valid && item_ch.ready)
				expected_outcomes.insert(expected_outcomes.size(), predict_outcome('{
					opcode: item_ch.opcode,
					card_uid: item_ch.card_uid,
					card_uid_len: item_ch.card_uid_len,
					entry_index: item_ch.entry_index,
					entry_valid: item_ch.entry_valid,
					switch_closed: item_ch.switch_closed}));
		end
	end

	initial begin
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_NOP;
		item_ch.card_uid = '0;
		item_ch.card_uid_len = '0;
		item_ch.entry_index = '0;
		item_ch.entry_valid = 1'b0;
		item_ch.switch_closed = 1'b0;
		res_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		cfg = '{hold_ms: HOLD_RST, cooldown_ms: COOLDOWN_RST, pulse_ms: PULSE_RST,
			strong_duty: STRONG_RST, weak_duty: WEAK_RST};
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
			acl_uid[i] = '0;
			acl_len[i] = '0;
			acl_ok[i] = 1'b0;
			gen_set[i] = 1'b0;
		end
		prev_uid = '0;
		prev_len = '0;
		prev_seen = 1'b0;
		since_card = SINCE_MAX;
		unlocked = 1'b0;
		pulse_cnt = '0;
		held = '0;
		duty = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset configuration: table extremes, cooldown, zero lengths, denial.
		add_req(write_item(0, UID_ONES, 7, 1'b1));
		add_req(write_item(15, 56'hAB, 1, 1'b1));
		add_req(write_item(7, 56'h0, 0, 1'b1));
		add_req(write_item(3, 56'hDEAD_BEEF, 4, 1'b0));
		add_req(card_item(UID_ONES, 7));
		add_req(card_item(UID_ONES, 7));
		add_req(tick_item(1'b1));
		add_req(card_item(56'hAB, 1));
		add_req(card_item(rand_uid(), 0));
		add_req(card_item(56'hDEAD_BEEF, 4));
		add_req(card_item(56'h0, 3));
		add_req(noise_item(OP_NOP));
		add_req(write_item(3, 56'hDEAD_BEEF, 4, 1'b1));
		add_req(card_item(56'hDEAD_BEEF, 4));
		add_req(tick_item(1'b0));
		add_req(tick_item(1'b1));
		add_req(card_item(56'hDEAD_BEEF, 4));
		drain();

		// Short timings; a grant held with the switch closed runs into the timeout.
		set_cfg(3, 4, 2, 200, 30);
		add_req(card_item(UID_ONES, 7));
		repeat (10) add_req(tick_item(1'b1));
		push_random(160);
		drain();

		set_cfg(1, 0, 0, 0, 255);
		push_random(100);
		drain();

		set_cfg(2, 1, 1, 0, 0);
		push_random(80);
		drain();

		// Longest timings: repeats stay inside the cooldown and the pulse keeps running.
		set_cfg(65535, 65535, 1023, 255, 255);
		add_req(write_item(5, 56'h5A_A5C3_3C0F, 5, 1'b1));
		add_req(card_item(56'h5A_A5C3_3C0F, 5));
		repeat (20) add_req(tick_item(1'b1));
		add_req(card_item(56'h5A_A5C3_3C0F, 5));
		repeat (4) add_req(tick_item(1'b0));
		add_req(card_item(56'h5A_A5C3_3C0F, 5));
		repeat (2) add_req(tick_item(1'b1));
		drain();

		set_cfg(4, 2, 3, 128, 64);
		push_random(110);
		drain();

		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
